>>> hw/rtl/aes128_pkg.sv
// Shared types, tables and byte-level functions for the AES-128 cipher.
package aes128_pkg;

  localparam int unsigned NUM_ROUNDS = 10;

  // Configuration register indexes
  localparam logic REG_KEY_UPPER = 1'b0;
  localparam logic REG_KEY_LOWER = 1'b1;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_EXPAND
  } ks_state_t;

  // Round keys from the key scheduler to the datapath
  typedef struct packed {
    logic                busy;
    logic [10:0][127:0]  enc;  // encryption round keys 0..10
    logic [9:1][127:0]   dec;  // InvMixColumns of encryption keys 1..9
  } ks_keys_t;

  localparam logic [7:0] RCON [1:10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte i sits at bits 127-8i downto 120-8i; column c is bytes 4c..4c+3
  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = SBOX[s[8*i +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[8*i +: 8] = INV_SBOX[s[8*i +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) % 4)) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] d [4];
    for (int i = 0; i < 4; i++) begin
      a[i] = w[31 - 8*i -: 8];
      d[i] = xtime(a[i]);
    end
    return {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
            a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
            a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
            d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]   = w[31 - 8*i -: 8];
      x2     = xtime(a[i]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[i]  = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) t[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32]);
    return t;
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) t[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
    return t;
  endfunction

  // One step of the key expansion: the next round key from the previous one
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

>>> hw/rtl/aes128_key_sched.sv
// Key register pair and iterative round key expansion, one round key per cycle.
module aes128_key_sched (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data,
  output aes128_pkg::ks_keys_t keys
);

  aes128_pkg::ks_state_t state, state_next;
  logic [63:0]  key_upper;
  logic [63:0]  key_lower;
  logic [3:0]   cnt;
  logic [127:0] cur;
  logic [127:0] enc [0:10];
  logic [127:0] dec [1:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aes128_pkg::KS_LOAD;
      key_upper <= '0;
      key_lower <= '0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == aes128_pkg::REG_KEY_UPPER) key_upper <= cfg_data;
      if (cfg_write && cfg_index == aes128_pkg::REG_KEY_LOWER) key_lower <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      aes128_pkg::KS_IDLE: begin
        if (cfg_write) state_next = aes128_pkg::KS_LOAD;
      end
      aes128_pkg::KS_LOAD: begin
        state_next = aes128_pkg::KS_EXPAND;
      end
      aes128_pkg::KS_EXPAND: begin
        if (cnt == 4'(aes128_pkg::NUM_ROUNDS)) state_next = aes128_pkg::KS_IDLE;
      end
      default: state_next = aes128_pkg::KS_IDLE;
    endcase
  end

  // cur holds round key cnt-1; its InvMixColumns form is written alongside
  always_ff @(posedge clk) begin
    if (state == aes128_pkg::KS_LOAD) begin
      cur    <= {key_upper, key_lower};
      enc[0] <= {key_upper, key_lower};
      cnt    <= 4'd1;
    end else if (state == aes128_pkg::KS_EXPAND) begin
      cur      <= aes128_pkg::next_round_key(cur, aes128_pkg::RCON[cnt]);
      enc[cnt] <= aes128_pkg::next_round_key(cur, aes128_pkg::RCON[cnt]);
      if (cnt >= 4'd2) dec[cnt - 4'd1] <= aes128_pkg::inv_mix_columns(cur);
      cnt <= cnt + 4'd1;
    end
  end

  always_comb begin
    keys.busy = (state != aes128_pkg::KS_IDLE);
    for (int r = 0; r <= 10; r++) keys.enc[r] = enc[r];
    for (int r = 1; r <= 9; r++) keys.dec[r] = dec[r];
  end

endmodule

>>> hw/rtl/aes128_round.sv
// One registered cipher round, forward or equivalent inverse, chosen per beat.
module aes128_round (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         final_round,
  input  logic         in_valid,
  input  logic         in_action,
  input  logic [127:0] in_state,
  input  logic [127:0] enc_key,
  input  logic [127:0] dec_key,
  output logic         out_valid,
  output logic         out_action,
  output logic [127:0] out_state
);

  logic [127:0] fwd_sr, fwd_mc, inv_sb, inv_mc, result;

  always_comb begin
    fwd_sr = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(in_state));
    fwd_mc = final_round ? fwd_sr : aes128_pkg::mix_columns(fwd_sr);
    inv_sb = aes128_pkg::inv_sub_bytes(aes128_pkg::inv_shift_rows(in_state));
    inv_mc = final_round ? inv_sb : aes128_pkg::inv_mix_columns(inv_sb);
    result = (in_action == aes128_pkg::ACT_DECRYPT) ? (inv_mc ^ dec_key)
                                                    : (fwd_mc ^ enc_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= in_action;
      out_state  <= result;
    end
  end

endmodule

>>> hw/rtl/aes128_block_cipher.sv
// Top level of the pipelined AES-128 ECB block cipher.
//
// AES-128 encrypt/decrypt engine, one block per beat, one beat per cycle
// while tready is high. A beat on the input side carries the 128-bit block
// in tdata (block_upper in bits 63:0, block_lower in bits 127:64, byte 0 of
// the block in bit 63..56) and the action in tuser (0 encrypt, 1 decrypt).
// Encrypt and decrypt beats may be mixed freely. The datapath is eleven
// register stages: the initial key addition, then one stage per round, the
// last of which is the output register. The whole pipeline advances whenever
// the output register is empty or being taken, so a stall on the output side
// freezes every stage and nothing is lost or repeated. Decryption uses the
// equivalent inverse cipher with InvMixColumns-folded round keys. The key is
// written through the configuration port as two 64-bit halves (index 0 upper,
// index 1 lower); every write made while no expansion is running starts a key
// expansion (a load step, then one round key per cycle), during which tready
// is held low. The same expansion runs on the all-zero key after reset, so the
// block accepts its first beat once it is done. Write the key only while no
// blocks are in flight.
module aes128_block_cipher (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_upper[63:0], block_lower[127:64]
  input  logic         s_axis_tuser,  // action[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // out_upper[63:0], out_lower[127:64]
);

  aes128_pkg::ks_keys_t keys;

  logic               advance;
  logic               vld [0:10];
  logic               act [0:10];
  logic [127:0]       st  [0:10];
  logic [127:0]       in_block;

  aes128_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // Advance all stages together unless the output register holds a beat
  // that is not being taken
  assign advance       = !vld[10] || m_axis_tready;
  assign s_axis_tready = advance && !keys.busy;
  assign in_block      = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  // Stage 0: whitening with round key 0 (encrypt) or round key 10 (decrypt)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act[0] <= s_axis_tuser;
      st[0]  <= in_block ^ ((s_axis_tuser == aes128_pkg::ACT_DECRYPT) ? keys.enc[10]
                                                                      : keys.enc[0]);
    end
  end

  // Round j uses encryption key j, or the folded key of round 10-j when
  // decrypting; the last inverse round takes the plain key 0
  for (genvar j = 1; j <= 10; j++) begin : g_round
    aes128_round u_round (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .final_round (j == 10),
      .in_valid    (vld[j-1]),
      .in_action   (act[j-1]),
      .in_state    (st[j-1]),
      .enc_key     (keys.enc[j]),
      .dec_key     ((j == 10) ? keys.enc[0] : keys.dec[(j == 10) ? 1 : 10 - j]),
      .out_valid   (vld[j]),
      .out_action  (act[j]),
      .out_state   (st[j])
    );
  end

  assign m_axis_tvalid = vld[10];
  assign m_axis_tdata  = {st[10][63:0], st[10][127:64]};

endmodule

>>> sim/aes128_block_cipher_checker.sv
// Scoreboard for the AES-128 block cipher: key tracking, block prediction, result compare.
module aes128_block_cipher_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  output int           failures,
  output int           outstanding
);

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } block_t;

  logic [7:0]   fwd_sbox [256];
  logic [7:0]   rev_sbox [256];
  logic [63:0]  cur_key_upper;
  logic [63:0]  cur_key_lower;
  logic [127:0] round_keys [11];
  block_t       pending_blocks [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inverse(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gf_mul(r, a);
    return r;
  endfunction

  // Byte i of a state lives at bits 127-8i downto 120-8i
  function automatic logic [127:0] substitute(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++)
      t[127 - 8*i -: 8] = inv ? rev_sbox[s[127 - 8*i -: 8]] : fwd_sbox[s[127 - 8*i -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
        else     t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) % 4)) -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   coef [4];
    logic [7:0]   acc;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mul(s[127 - 8*(4*c + k) -: 8], coef[(k - row + 4) % 4]);
        t[127 - 8*(4*c + row) -: 8] = acc;
      end
    return t;
  endfunction

  task automatic expand_round_keys();
    logic [31:0] t;
    logic [7:0]  rcon;
    logic [127:0] p;
    round_keys[0] = {cur_key_upper, cur_key_lower};
    rcon = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      p = round_keys[r-1];
      t = {fwd_sbox[p[23:16]] ^ rcon, fwd_sbox[p[15:8]], fwd_sbox[p[7:0]], fwd_sbox[p[31:24]]};
      round_keys[r][127:96] = p[127:96] ^ t;
      round_keys[r][95:64]  = p[95:64] ^ round_keys[r][127:96];
      round_keys[r][63:32]  = p[63:32] ^ round_keys[r][95:64];
      round_keys[r][31:0]   = p[31:0] ^ round_keys[r][63:32];
      rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
    end
  endtask

  // Forward cipher, or the plain inverse cipher for decrypt: same result as the equivalent form the block uses
  function automatic block_t cipher_block(input logic act, input block_t blk);
    logic [127:0] s;
    s = blk;
    if (act == aes128_pkg::ACT_ENCRYPT) begin
      s ^= round_keys[0];
      for (int r = 1; r <= 10; r++) begin
        s = rotate_rows(substitute(s, 1'b0), 1'b0);
        if (r != 10) s = mix_state(s, 1'b0);
        s ^= round_keys[r];
      end
    end else begin
      s ^= round_keys[10];
      for (int r = 9; r >= 0; r--) begin
        s = substitute(rotate_rows(s, 1'b1), 1'b1) ^ round_keys[r];
        if (r != 0) s = mix_state(s, 1'b1);
      end
    end
    return s;
  endfunction

  initial begin
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = gf_inverse(x[7:0]);
      fwd_sbox[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) rev_sbox[fwd_sbox[x]] = x[7:0];
  end

  always @(posedge clk) begin
    block_t got, want;
    if (rst) begin
      cur_key_upper = '0;
      cur_key_lower = '0;
      expand_round_keys();
      pending_blocks.delete();
      failures = 0;
    end else begin
      // Keys change only while nothing is in flight, so order against beats is moot
      if (cfg_write) begin
        if (cfg_index == aes128_pkg::REG_KEY_UPPER) cur_key_upper = cfg_data;
        else cur_key_lower = cfg_data;
        expand_round_keys();
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_blocks.push_back(cipher_block(s_axis_tuser,
                                              {s_axis_tdata[63:0], s_axis_tdata[127:64]}));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
        if (pending_blocks.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result beat %h %h", got.upper, got.lower);
        end else begin
          want = pending_blocks.pop_front();
          if (got.upper !== want.upper || got.lower !== want.lower) begin
            failures++;
            if (failures <= 10)
              $display("result mismatch: expected %h %h, got %h %h",
                       want.upper, want.lower, got.upper, got.lower);
          end
        end
      end
    end
    outstanding = pending_blocks.size();
  end

endmodule

>>> sim/tb.sv
// Top of the AES-128 block cipher testbench: clock, reset, stimulus and verdict.
module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_write = 1'b0;
  logic         cfg_index = aes128_pkg::REG_KEY_UPPER;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // block_upper[63:0], block_lower[127:64]
  logic         s_axis_tuser = aes128_pkg::ACT_ENCRYPT;  // action[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;  // out_upper[63:0], out_lower[127:64]
  int           failures;
  int           outstanding;
  int           cycle_count = 0;
  int           sink_stall = 0;
  bit           no_gaps = 1'b0;

  always #10 clk = ~clk;

  aes128_block_cipher dut (.*);

  aes128_block_cipher_checker checker_i (.*);

  // Run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: mostly ready, short stalls, a few long ones, and
  // recurring stretches of steady readiness
  always @(posedge clk) begin
    if (cycle_count[9:8] == 2'd0) begin
      m_axis_tready <= 1'b1;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_block(input logic act, input logic [63:0] upper, input logic [63:0] lower);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = (no_gaps || pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {lower, upper};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drain the pipeline, let the block settle, then write one key half
  task automatic write_key(input logic idx, input logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (15) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] ku;
    logic [63:0] kl;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // All-zero key from reset: field extremes and both actions
    send_block(aes128_pkg::ACT_ENCRYPT, '0, '0);
    send_block(aes128_pkg::ACT_DECRYPT, '0, '0);
    send_block(aes128_pkg::ACT_ENCRYPT, '1, '1);
    send_block(aes128_pkg::ACT_DECRYPT, '1, '1);
    send_block(aes128_pkg::ACT_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_block(aes128_pkg::ACT_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(aes128_pkg::ACT_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);

    // Upper half alone: expansion mixes it with the old lower half
    write_key(aes128_pkg::REG_KEY_UPPER, 64'h0001_0203_0405_0607);
    send_block(aes128_pkg::ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(aes128_pkg::ACT_DECRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);

    // Second half completes the standard test key
    write_key(aes128_pkg::REG_KEY_LOWER, 64'h0809_0a0b_0c0d_0e0f);
    send_block(aes128_pkg::ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(aes128_pkg::ACT_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    send_block(aes128_pkg::ACT_ENCRYPT, '1, '0);
    send_block(aes128_pkg::ACT_DECRYPT, '0, '1);

    // All-ones key
    write_key(aes128_pkg::REG_KEY_UPPER, '1);
    write_key(aes128_pkg::REG_KEY_LOWER, '1);
    send_block(aes128_pkg::ACT_ENCRYPT, '0, '0);
    send_block(aes128_pkg::ACT_DECRYPT, '0, '0);
    send_block(aes128_pkg::ACT_ENCRYPT, '1, '1);
    send_block(aes128_pkg::ACT_DECRYPT, '1, '1);

    // Random phases: new key (sometimes one half only), then random blocks
    for (int p = 0; p < 9; p++) begin
      ku = rand_word();
      kl = rand_word();
      case ($urandom_range(0, 3))
        0: write_key(aes128_pkg::REG_KEY_UPPER, ku);
        1: write_key(aes128_pkg::REG_KEY_LOWER, kl);
        default: begin
          write_key(aes128_pkg::REG_KEY_UPPER, ku);
          write_key(aes128_pkg::REG_KEY_LOWER, kl);
        end
      endcase
      no_gaps = (p % 3 == 0);
      for (int n = 0; n < 115; n++)
        send_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
    end

    // Finish on the zero key so both halves return to the low extreme
    write_key(aes128_pkg::REG_KEY_UPPER, '0);
    write_key(aes128_pkg::REG_KEY_LOWER, '0);
    for (int n = 0; n < 10; n++)
      send_block(1'($urandom_range(0, 1)), rand_word(), rand_word());

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
